/* rtl/mobm_pkg.sv */
// Package with the shared types and constants of the median-of-block-means estimator.
`default_nettype none

package mobm_pkg;

   localparam int COLOR_W  = 32;
   localparam int WEIGHT_W = 16;
   localparam int LUM_W    = 50;
   localparam int BCNT_W   = 5;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [BCNT_W-1:0]   BLOCK_COUNT_RESET  = 5'd8;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RESET   = 16'd13933;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RESET = 16'd46871;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RESET  = 16'd4732;

   typedef enum logic [1:0] {
      REG_BLOCK_COUNT  = 2'd0,
      REG_WEIGHT_RED   = 2'd1,
      REG_WEIGHT_GREEN = 2'd2,
      REG_WEIGHT_BLUE  = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_ACC,
      ST_START,
      ST_DIV,
      ST_MUL,
      ST_LUM,
      ST_INS,
      ST_POP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [LUM_W-1:0]   lum;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/mobm_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mobm_div
   import mobm_pkg::*;
#(
   parameter int DVD_W = 48,
   parameter int DVS_W = 17
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DVD_W-1:0]   dividend,
   input  wire logic [DVS_W-1:0]   divisor,
   output logic                    done,
   output logic [COLOR_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [COLOR_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DVS_W:0]     trial;
   logic               qbit;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      qbit    = (trial >= {1'b0, dvs_ff});
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CNT_W'(DVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in = qbit ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         quo_in = {quo_ff[COLOR_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* rtl/mobm_sort_cell.sv */
// One cell of the insertion sorting chain, ordered by ascending luminance.
`default_nettype none

module mobm_sort_cell
   import mobm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     new_entry,
   input  wire logic          prev_ins,
   input  wire logic          prev_valid,
   input  wire entry_type     prev_entry,
   input  wire logic          next_valid,
   input  wire entry_type     next_entry,
   output logic               ins,
   output logic               valid,
   output entry_type          entry
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   always_comb begin
      ins      = !valid_ff || (new_entry.lum < entry_ff.lum);
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert && ins) begin
         entry_in = prev_ins ? prev_entry : new_entry;
         valid_in = prev_ins ? prev_valid : 1'b1;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

/* rtl/median_of_block_means.sv */
// Top level of the median-of-block-means estimator: accumulation, finish sequencer, sorter.
// Samples stream at one per cycle while req_ready is high, only in the accumulate state.
// A last sample starts a finish pass: for each block, bit-serial dividers (one per channel,
// one quotient bit per cycle, SUM_W = 48 bits) form the means, sorted by luminance.
// The next sample is taken once the result is in the output register.
// Reset is synchronous: registers return to 8, 13933, 46871, 4732 and all sums clear.
`default_nettype none

module median_of_block_means
   import mobm_pkg::*;
#(
   parameter int MAX_BLOCKS  = 16,
   parameter int MAX_SAMPLES = 65536
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [COLOR_W-1:0]  req_red_in,
   input  wire logic [COLOR_W-1:0]  req_green_in,
   input  wire logic [COLOR_W-1:0]  req_blue_in,
   input  wire logic                req_last_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [COLOR_W-1:0]       rsp_red_out,
   output logic [COLOR_W-1:0]       rsp_green_out,
   output logic [COLOR_W-1:0]       rsp_blue_out,
   output logic                     rsp_empty_block,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [ADDR_W-1:0]   paddr,
   input  wire logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   localparam int SUM_W   = COLOR_W + $clog2(MAX_SAMPLES);
   localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int NUM_W   = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W  = COLOR_W + WEIGHT_W;

   // Configuration registers.
   logic [BCNT_W-1:0]   block_count_ff;
   logic [WEIGHT_W-1:0] weight_red_ff, weight_green_ff, weight_blue_ff;
   logic                cfg_wr;
   reg_idx_type         cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = reg_idx_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff  <= BLOCK_COUNT_RESET;
         weight_red_ff   <= WEIGHT_RED_RESET;
         weight_green_ff <= WEIGHT_GREEN_RESET;
         weight_blue_ff  <= WEIGHT_BLUE_RESET;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_BLOCK_COUNT:  block_count_ff  <= pwdata[BCNT_W-1:0];
            REG_WEIGHT_RED:   weight_red_ff   <= pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_GREEN: weight_green_ff <= pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_BLUE:  weight_blue_ff  <= pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_BLOCK_COUNT:  prdata = DATA_W'(block_count_ff);
         REG_WEIGHT_RED:   prdata = DATA_W'(weight_red_ff);
         REG_WEIGHT_GREEN: prdata = DATA_W'(weight_green_ff);
         REG_WEIGHT_BLUE:  prdata = DATA_W'(weight_blue_ff);
         default:          prdata = '0;
      endcase
   end

   // Effective block count.
   logic [NUM_W-1:0] n_eff;
   logic [NUM_W-1:0] half;

   always_comb begin
      if (block_count_ff == '0) begin
         n_eff = NUM_W'(1);
      end else if (32'(block_count_ff) > 32'(MAX_BLOCKS)) begin
         n_eff = NUM_W'(MAX_BLOCKS);
      end else begin
         n_eff = NUM_W'(block_count_ff);
      end
      half = n_eff >> 1;
   end

   // State and control.
   state_type        state_ff, state_in;
   logic             accept;
   logic             take;
   logic             div_start;
   logic             div_done;
   logic             out_free;
   logic             emit;
   logic             last_blk;
   logic             pop_end;
   cell_ctrl_type    cell_ctrl;
   logic             rsp_valid_ff;

   logic [IDX_W-1:0]   next_ff, next_in;
   logic [IDX_W-1:0]   k;
   logic [TALLY_W-1:0] taken_ff;
   logic [IDX_W-1:0]   blk_ff;
   logic [NUM_W-1:0]   pc_ff;

   assign accept   = req_valid && req_ready;
   assign take     = 32'(taken_ff) < 32'(MAX_SAMPLES);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_blk = (32'(blk_ff) + 1) == 32'(n_eff);
   assign pop_end  = (pc_ff == half);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACC:   if (accept && req_last_sample) state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_MUL;
         ST_MUL:   state_in = ST_LUM;
         ST_LUM:   state_in = ST_INS;
         ST_INS:   state_in = last_blk ? ST_POP : ST_START;
         ST_POP:   if (pop_end) state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_ACC;
         default:  state_in = ST_ACC;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == ST_ACC);
      div_start        = (state_ff == ST_START);
      emit             = (state_ff == ST_EMIT) && out_free;
      cell_ctrl.insert = (state_ff == ST_INS);
      cell_ctrl.shift  = (state_ff == ST_POP);
      cell_ctrl.clear  = emit;
   end

   // Block accumulators.
   logic [SUM_W-1:0]   sum_r_ff [MAX_BLOCKS];
   logic [SUM_W-1:0]   sum_g_ff [MAX_BLOCKS];
   logic [SUM_W-1:0]   sum_b_ff [MAX_BLOCKS];
   logic [TALLY_W-1:0] tally_ff [MAX_BLOCKS];

   always_comb begin
      k       = (32'(next_ff) < 32'(n_eff)) ? next_ff : '0;
      next_in = ((32'(k) + 1) >= 32'(n_eff)) ? '0 : IDX_W'(32'(k) + 1);
   end

   always_ff @(posedge clock) begin
      if (reset || emit) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            sum_r_ff[i] <= '0;
            sum_g_ff[i] <= '0;
            sum_b_ff[i] <= '0;
            tally_ff[i] <= '0;
         end
         next_ff  <= '0;
         taken_ff <= '0;
      end else if (accept && take) begin
         sum_r_ff[k] <= sum_r_ff[k] + SUM_W'(req_red_in);
         sum_g_ff[k] <= sum_g_ff[k] + SUM_W'(req_green_in);
         sum_b_ff[k] <= sum_b_ff[k] + SUM_W'(req_blue_in);
         tally_ff[k] <= tally_ff[k] + 1'b1;
         next_ff     <= next_in;
         taken_ff    <= taken_ff + 1'b1;
      end
   end

   // Dividers, one per channel.
   logic [COLOR_W-1:0] quo_r, quo_g, quo_b;
   logic               done_r, done_g, done_b;

   mobm_div #(.DVD_W(SUM_W), .DVS_W(TALLY_W)) u_div_r (
      .clock, .reset, .start(div_start), .dividend(sum_r_ff[blk_ff]),
      .divisor(tally_ff[blk_ff]), .done(done_r), .quotient(quo_r)
   );
   mobm_div #(.DVD_W(SUM_W), .DVS_W(TALLY_W)) u_div_g (
      .clock, .reset, .start(div_start), .dividend(sum_g_ff[blk_ff]),
      .divisor(tally_ff[blk_ff]), .done(done_g), .quotient(quo_g)
   );
   mobm_div #(.DVD_W(SUM_W), .DVS_W(TALLY_W)) u_div_b (
      .clock, .reset, .start(div_start), .dividend(sum_b_ff[blk_ff]),
      .divisor(tally_ff[blk_ff]), .done(done_b), .quotient(quo_b)
   );

   assign div_done = done_r && done_g && done_b;

   // Mean, luminance and sequencing registers.
   logic               zero_ff;
   logic               empty_ff;
   entry_type          mean_ff;
   logic [PROD_W-1:0]  prod_r_ff, prod_g_ff, prod_b_ff;
   logic [COLOR_W-1:0] lo_r_ff, lo_g_ff, lo_b_ff;
   logic [COLOR_W-1:0] hi_r_ff, hi_g_ff, hi_b_ff;
   entry_type          head;

   always_ff @(posedge clock) begin
      if (state_ff == ST_START) begin
         zero_ff <= (tally_ff[blk_ff] == '0);
      end
      if (state_ff == ST_MUL) begin
         mean_ff.red   <= zero_ff ? '0 : quo_r;
         mean_ff.green <= zero_ff ? '0 : quo_g;
         mean_ff.blue  <= zero_ff ? '0 : quo_b;
         prod_r_ff     <= zero_ff ? '0 : quo_r * weight_red_ff;
         prod_g_ff     <= zero_ff ? '0 : quo_g * weight_green_ff;
         prod_b_ff     <= zero_ff ? '0 : quo_b * weight_blue_ff;
      end
      if (state_ff == ST_LUM) begin
         mean_ff.lum <= LUM_W'(prod_r_ff) + LUM_W'(prod_g_ff) + LUM_W'(prod_b_ff);
      end
      if (state_ff == ST_POP) begin
         if (!n_eff[0] && (32'(pc_ff) + 1) == 32'(half)) begin
            lo_r_ff <= head.red;
            lo_g_ff <= head.green;
            lo_b_ff <= head.blue;
         end
         if (pop_end) begin
            hi_r_ff <= head.red;
            hi_g_ff <= head.green;
            hi_b_ff <= head.blue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         blk_ff   <= '0;
         pc_ff    <= '0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_START && tally_ff[blk_ff] == '0) begin
            empty_ff <= 1'b1;
         end
         if (state_ff == ST_INS) begin
            blk_ff <= last_blk ? '0 : blk_ff + 1'b1;
            pc_ff  <= '0;
         end
         if (state_ff == ST_POP) begin
            pc_ff <= pc_ff + 1'b1;
         end
         if (emit) begin
            empty_ff <= 1'b0;
         end
      end
   end

   // Sorting chain.
   logic      ins_vec   [MAX_BLOCKS];
   logic      valid_vec [MAX_BLOCKS];
   entry_type ent_vec   [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] valid_bits;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic      p_ins;
      logic      p_val;
      entry_type p_ent;
      logic      n_val;
      entry_type n_ent;

      if (i == 0) begin : g_first
         assign p_ins = 1'b0;
         assign p_val = 1'b0;
         assign p_ent = mean_ff;
      end else begin : g_rest
         assign p_ins = ins_vec[i-1];
         assign p_val = valid_vec[i-1];
         assign p_ent = ent_vec[i-1];
      end
      if (i == MAX_BLOCKS - 1) begin : g_last
         assign n_val = 1'b0;
         assign n_ent = ent_vec[i];
      end else begin : g_mid
         assign n_val = valid_vec[i+1];
         assign n_ent = ent_vec[i+1];
      end

      mobm_sort_cell u_cell (
         .clock, .reset, .ctrl(cell_ctrl), .new_entry(mean_ff),
         .prev_ins(p_ins), .prev_valid(p_val), .prev_entry(p_ent),
         .next_valid(n_val), .next_entry(n_ent),
         .ins(ins_vec[i]), .valid(valid_vec[i]), .entry(ent_vec[i])
      );
      assign valid_bits[i] = valid_vec[i];
   end

   assign head = ent_vec[0];

   // Output register.
   logic [COLOR_W-1:0] out_r_ff, out_g_ff, out_b_ff;
   logic               out_e_ff;
   logic [COLOR_W:0]   avg_r, avg_g, avg_b;

   always_comb begin
      avg_r = {1'b0, lo_r_ff} + {1'b0, hi_r_ff};
      avg_g = {1'b0, lo_g_ff} + {1'b0, hi_g_ff};
      avg_b = {1'b0, lo_b_ff} + {1'b0, hi_b_ff};
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_r_ff <= n_eff[0] ? hi_r_ff : avg_r[COLOR_W:1];
         out_g_ff <= n_eff[0] ? hi_g_ff : avg_g[COLOR_W:1];
         out_b_ff <= n_eff[0] ? hi_b_ff : avg_b[COLOR_W:1];
         out_e_ff <= empty_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_out     = out_r_ff;
   assign rsp_green_out   = out_g_ff;
   assign rsp_blue_out    = out_b_ff;
   assign rsp_empty_block = out_e_ff;

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS |=> $countones(valid_bits) == $past($countones(valid_bits)) + 1)
      else $error("Sorter did not grow by one entry on insert.");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      emit |=> valid_bits == '0)
      else $error("Sorter not empty after a result was emitted.");

   a_taken_bound : assert property (@(posedge clock) disable iff (reset)
      32'(taken_ff) <= 32'(MAX_SAMPLES))
      else $error("Sample total exceeded its limit.");

   a_div_done_state : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("Divider finished outside the divide state.");

endmodule

`default_nettype wire

/* test/median_of_block_means_tb.sv */
// Self-checking testbench for the median-of-block-means estimator with its own predictor.
`default_nettype none

module median_of_block_means_tb;
   import mobm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBLK = 16;
   localparam int SAMPLE_CAP = 65536;

   typedef struct {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               empty;
   } pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [COLOR_W-1:0]  req_red_in = '0;
   logic [COLOR_W-1:0]  req_green_in = '0;
   logic [COLOR_W-1:0]  req_blue_in = '0;
   logic                req_last_sample = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COLOR_W-1:0]  rsp_red_out;
   logic [COLOR_W-1:0]  rsp_green_out;
   logic [COLOR_W-1:0]  rsp_blue_out;
   logic                rsp_empty_block;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   median_of_block_means i_dut (.*);

   logic [BCNT_W-1:0]   cfg_count;
   logic [WEIGHT_W-1:0] cfg_wr, cfg_wg, cfg_wb;
   logic [47:0]         acc_red[NBLK], acc_green[NBLK], acc_blue[NBLK];
   logic [16:0]         acc_tally[NBLK];
   int                  deal_ptr, pixel_taken;
   pixel_type           pending_pixels[$];
   int                  fail_count = 0;
   bit                  busy_mode = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!busy_mode || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      forever begin
         @(negedge clock);
         rsp_ready = 1'b1;
         if (busy_mode && $urandom_range(99) < 30) begin
            rsp_ready = 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end
      end
   end

   function automatic void clear_accumulators();
      for (int i = 0; i < NBLK; i++) begin
         acc_red[i] = '0;
         acc_green[i] = '0;
         acc_blue[i] = '0;
         acc_tally[i] = '0;
      end
      deal_ptr = 0;
      pixel_taken = 0;
   endfunction

   function automatic void accumulate_sample(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                             logic [COLOR_W-1:0] b, logic last);
      int n, k, idx;
      logic [31:0] mr[NBLK], mg[NBLK], mb[NBLK];
      logic [63:0] lum[NBLK];
      int rank[NBLK];
      pixel_type px;
      logic [32:0] avg;
      n = (cfg_count == 0) ? 1 : (cfg_count > NBLK) ? NBLK : cfg_count;
      if (pixel_taken < SAMPLE_CAP) begin
         k = (deal_ptr < n) ? deal_ptr : 0;
         acc_red[k] += r;
         acc_green[k] += g;
         acc_blue[k] += b;
         acc_tally[k] += 1;
         pixel_taken++;
         deal_ptr = (k + 1 >= n) ? 0 : k + 1;
      end
      if (!last) return;
      px.empty = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (acc_tally[i] == 0) begin
            mr[i] = '0;
            mg[i] = '0;
            mb[i] = '0;
            px.empty = 1'b1;
         end else begin
            mr[i] = 32'(acc_red[i] / acc_tally[i]);
            mg[i] = 32'(acc_green[i] / acc_tally[i]);
            mb[i] = 32'(acc_blue[i] / acc_tally[i]);
         end
         lum[i] = 64'(cfg_wr) * mr[i] + 64'(cfg_wg) * mg[i] + 64'(cfg_wb) * mb[i];
         rank[i] = i;
      end
      for (int i = 1; i < n; i++) begin
         idx = rank[i];
         k = i;
         while (k > 0 && lum[idx] < lum[rank[k-1]]) begin
            rank[k] = rank[k-1];
            k--;
         end
         rank[k] = idx;
      end
      if (n % 2 == 0) begin
         avg = (33'(mr[rank[n/2]]) + mr[rank[n/2-1]]) >> 1;
         px.red = avg[31:0];
         avg = (33'(mg[rank[n/2]]) + mg[rank[n/2-1]]) >> 1;
         px.green = avg[31:0];
         avg = (33'(mb[rank[n/2]]) + mb[rank[n/2-1]]) >> 1;
         px.blue = avg[31:0];
      end else begin
         px.red = mr[rank[n/2]];
         px.green = mg[rank[n/2]];
         px.blue = mb[rank[n/2]];
      end
      pending_pixels = {pending_pixels, px};
      clear_accumulators();
   endfunction

   always @(posedge clock) begin
      pixel_type px;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result item");
            fail_count++;
         end else begin
            px = pending_pixels.pop_front();
            if (rsp_red_out !== px.red) begin
               $error("red_out: expected %0h, got %0h", px.red, rsp_red_out);
               fail_count++;
            end
            if (rsp_green_out !== px.green) begin
               $error("green_out: expected %0h, got %0h", px.green, rsp_green_out);
               fail_count++;
            end
            if (rsp_blue_out !== px.blue) begin
               $error("blue_out: expected %0h, got %0h", px.blue, rsp_blue_out);
               fail_count++;
            end
            if (rsp_empty_block !== px.empty) begin
               $error("empty_block: expected %0b, got %0b", px.empty, rsp_empty_block);
               fail_count++;
            end
         end
      end
   end

   task automatic send_sample(logic [31:0] r, logic [31:0] g, logic [31:0] b, logic last);
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_red_in = r;
      req_green_in = g;
      req_blue_in = b;
      req_last_sample = last;
      do @(posedge clock); while (!req_ready);
      accumulate_sample(r, g, b, last);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(reg_idx_type which, logic [31:0] value);
      wait_drained();
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = ADDR_W'(4 * int'(which));
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         REG_BLOCK_COUNT: cfg_count = value[BCNT_W-1:0];
         REG_WEIGHT_RED: cfg_wr = value[WEIGHT_W-1:0];
         REG_WEIGHT_GREEN: cfg_wg = value[WEIGHT_W-1:0];
         REG_WEIGHT_BLUE: cfg_wb = value[WEIGHT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         REG_BLOCK_COUNT: value = 32'(cfg_count);
         REG_WEIGHT_RED: value = 32'(cfg_wr);
         REG_WEIGHT_GREEN: value = 32'(cfg_wg);
         REG_WEIGHT_BLUE: value = 32'(cfg_wb);
         default: ;
      endcase
      if (prdata !== value) begin
         $error("prdata: expected %0h, got %0h", value, prdata);
         fail_count++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   function automatic logic [31:0] random_color();
      case ($urandom_range(5))
         0: return '1;
         1: return '0;
         2: return $urandom_range(0, 32'h0003_FFFF);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes();
      send_sample('1, '1, '1, 1'b1);
      send_sample('0, '0, '0, 1'b0);
      send_sample('1, '0, 32'h0001_0000, 1'b1);
      for (int i = 0; i < 8; i++) send_sample('1, '1, '1, i == 7);
      for (int i = 0; i < 8; i++) send_sample(32'(i), '1, 32'(7 - i), i == 7);
   endtask

   task automatic test_config_edges();
      write_register(REG_BLOCK_COUNT, 32'hFFFF_FFE0);
      send_sample(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b1);
      write_register(REG_BLOCK_COUNT, 32'd31);
      for (int i = 0; i < 6; i++) send_sample(random_color(), random_color(),
                                              random_color(), i == 5);
      write_register(REG_WEIGHT_RED, 32'hFFFF_0000);
      write_register(REG_WEIGHT_GREEN, 32'h0000_0000);
      write_register(REG_WEIGHT_BLUE, 32'h0001_FFFF);
      write_register(REG_BLOCK_COUNT, 32'd4);
      for (int i = 0; i < 4; i++) send_sample(32'd5, 32'd5, 32'd5, i == 3);
      write_register(REG_BLOCK_COUNT, 32'd16);
      for (int i = 0; i < 5; i++) send_sample(random_color(), '1, random_color(), 1'b0);
      write_register(REG_BLOCK_COUNT, 32'd3);
      for (int i = 0; i < 4; i++) send_sample(random_color(), random_color(),
                                              random_color(), i == 3);
   endtask

   task automatic test_random_pixels();
      int sent, len;
      logic [31:0] count_pick;
      sent = 0;
      while (sent < 1300) begin
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
               0: count_pick = 32'(16 + $urandom_range(16));
               1: count_pick = {27'($urandom_range(0, 32'h07FF_FFFF)), 5'd0};
               default: count_pick = $urandom_range(1, 16);
            endcase
            write_register(REG_BLOCK_COUNT, count_pick);
            write_register(reg_idx_type'($urandom_range(1, 3)), $urandom);
         end
         if ($urandom_range(9) == 0) busy_mode = ~busy_mode;
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
         for (int i = 0; i < len; i++)
            send_sample(random_color(), random_color(), random_color(), i == len - 1);
         sent += len;
      end
      busy_mode = 1'b1;
   endtask

   initial begin
      cfg_count = BLOCK_COUNT_RESET;
      cfg_wr = WEIGHT_RED_RESET;
      cfg_wg = WEIGHT_GREEN_RESET;
      cfg_wb = WEIGHT_BLUE_RESET;
      clear_accumulators();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_config_edges();
      test_random_pixels();
      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
